[rtl/core/chi_pkg.sv]
// Package for the coalesced hash insert block: widths, codes, the command and
// status structs shared by controller and datapath, and the PJW byte step.
// Depends on nothing.
package chi_pkg;

  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned KeyW        = 128;
  localparam int unsigned WordW       = 16;
  localparam int unsigned HashW       = 32;
  localparam int unsigned TsW         = 11;
  localparam int unsigned SlotW       = 10;
  localparam int unsigned StatusW     = 2;
  localparam logic [TsW-1:0]   TableSizeRst = 11'd1024;
  localparam logic [HashW-1:0] PjwTop       = 32'hF000_0000;

  typedef enum logic [StatusW-1:0] {
    StInserted  = 2'd0,
    StDuplicate = 2'd1,
    StFull      = 2'd2
  } status_e;

  typedef enum logic {
    AddrPos  = 1'b0,
    AddrFree = 1'b1
  } addr_sel_e;

  typedef enum logic [1:0] {
    SlotPos  = 2'd0,
    SlotFree = 2'd1,
    SlotZero = 2'd2
  } slot_sel_e;

  typedef struct packed {
    logic      load;
    logic      hash_step;
    logic      div_step;
    logic      pos_home;
    logic      pos_link;
    logic      clr_step;
    logic      scan_inc;
    logic      link_wr;
    logic      store_wr;
    addr_sel_e addr_sel;
    logic      pend_load;
    status_e   pend_status;
    slot_sel_e slot_sel;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic div_done;
    logic first;
    logic used;
    logic match;
    logic chain_end;
    logic fp_full;
    logic out_free;
  } sts_t;

  // One PJW step on a byte taken as a signed char.
  function automatic logic [HashW-1:0] pjw_step(logic [HashW-1:0] h, logic [7:0] b);
    logic [HashW-1:0] hn;
    logic [HashW-1:0] g;
    hn = (h << 4) + {{(HashW-8){b[7]}}, b};
    g  = hn & PjwTop;
    if (g != '0) begin
      hn = hn ^ (g >> 24) ^ g;
    end
    return hn;
  endfunction

endpackage

[rtl/core/chi_dp.sv]
// Datapath of the coalesced hash insert block: key and hash registers, the
// bit-serial modulo unit, the slot memories and the result register.
// Depends on chi_pkg.
module chi_dp #(
  parameter int unsigned CAPACITY = chi_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [chi_pkg::TsW-1:0]       cfg_wdata_i,
  input  logic [chi_pkg::KeyW-1:0]      key_i,
  input  chi_pkg::cmd_t                 cmd_i,
  output chi_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [chi_pkg::StatusW-1:0]   status_o,
  output logic [chi_pkg::SlotW-1:0]     slot_o
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned FpW = AW + 1;
  localparam int unsigned RW  = AW + 2;

  logic [chi_pkg::KeyW-1:0]  key_q;
  logic [chi_pkg::HashW-1:0] hash_q, hash_d;
  logic [4:0]                cnt_q;
  logic [RW-1:0]             rem_q, rem_sh, rem_d;
  logic [RW-1:0]             tsz_q, tsz_eff;
  logic [AW-1:0]             pos_q;
  logic [FpW-1:0]            steps_q;
  logic                      first_q;
  logic [FpW-1:0]            fp_q;
  logic [AW-1:0]             clr_q;
  logic [chi_pkg::TsW-1:0]   ts_q;
  chi_pkg::status_e          pend_status_q, out_status_q;
  logic [chi_pkg::SlotW-1:0] pend_slot_q, out_slot_q;
  logic                      out_valid_q;

  logic [chi_pkg::KeyW-1:0] key_mem [CAPACITY];
  logic [AW:0]              node_mem [CAPACITY];
  logic                     used_mem [CAPACITY];
  logic [chi_pkg::KeyW-1:0] key_rd_q;
  logic [AW:0]              node_rd_q;
  logic                     used_rd_q;

  logic [7:0][chi_pkg::WordW-1:0] words;
  logic [chi_pkg::WordW-1:0]      word_sel;
  logic [7:0]                     byte_sel;
  logic [31:0]                    ts_ext;
  logic [31:0]                    link_ext;
  logic [AW-1:0]                  rd_addr;
  logic                           hash_done, div_done;

  assign ts_ext  = 32'(ts_q);
  assign tsz_eff = (ts_q == '0 || ts_ext > CAPACITY) ? RW'(CAPACITY) : RW'(ts_ext);

  // Word a sits in the top bits of the key, so byte order runs from element 7 down.
  assign words    = key_q;
  assign word_sel = words[~cnt_q[3:1]];
  assign byte_sel = cnt_q[0] ? word_sel[15:8] : word_sel[7:0];
  assign hash_d   = chi_pkg::pjw_step(hash_q, byte_sel);

  assign rem_sh = {rem_q[RW-2:0], hash_q[chi_pkg::HashW-1]};
  assign rem_d  = (rem_sh >= tsz_q) ? rem_sh - tsz_q : rem_sh;

  assign hash_done = (cnt_q == 5'd15);
  assign div_done  = (cnt_q == 5'd31);

  assign rd_addr  = (cmd_i.addr_sel == chi_pkg::AddrFree) ? fp_q[AW-1:0] : pos_q;
  assign link_ext = 32'(node_rd_q[AW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      hash_q <= '0;
      rem_q <= '0;
      tsz_q <= tsz_eff;
      cnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hash_q <= hash_d;
      cnt_q <= hash_done ? 5'd0 : cnt_q + 5'd1;
    end else if (cmd_i.div_step) begin
      hash_q <= hash_q << 1;
      rem_q <= rem_d;
      cnt_q <= div_done ? 5'd0 : cnt_q + 5'd1;
    end
    if (cmd_i.pos_home) begin
      pos_q <= rem_q[AW-1:0];
      steps_q <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.pos_link) begin
      pos_q <= node_rd_q[AW-1:0];
      steps_q <= steps_q + FpW'(1);
      first_q <= 1'b0;
    end
    if (cmd_i.pend_load) begin
      pend_status_q <= cmd_i.pend_status;
      case (cmd_i.slot_sel)
        chi_pkg::SlotPos:  pend_slot_q <= chi_pkg::SlotW'(pos_q);
        chi_pkg::SlotFree: pend_slot_q <= chi_pkg::SlotW'(fp_q);
        default:           pend_slot_q <= '0;
      endcase
    end
    if (cmd_i.res_load) begin
      out_status_q <= pend_status_q;
      out_slot_q <= pend_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= '0;
      clr_q <= '0;
      ts_q <= chi_pkg::TableSizeRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ts_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_inc) begin
        fp_q <= fp_q + FpW'(1);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      used_mem[clr_q] <= 1'b0;
    end else if (cmd_i.store_wr) begin
      used_mem[rd_addr] <= 1'b1;
    end
    used_rd_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      key_mem[rd_addr] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr) begin
      node_mem[pos_q] <= {1'b0, fp_q[AW-1:0]};
    end else if (cmd_i.store_wr) begin
      node_mem[rd_addr] <= {1'b1, AW'(0)};
    end
    node_rd_q <= node_mem[rd_addr];
  end

  always_comb begin
    sts_o.clr_done  = (clr_q == AW'(CAPACITY - 1));
    sts_o.hash_done = hash_done;
    sts_o.div_done  = div_done;
    sts_o.first     = first_q;
    sts_o.used      = used_rd_q;
    sts_o.match     = (key_rd_q == key_q);
    sts_o.chain_end = node_rd_q[AW] || (steps_q >= FpW'(CAPACITY)) || (link_ext >= CAPACITY);
    sts_o.fp_full   = (fp_q >= FpW'(CAPACITY));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;

endmodule

[rtl/core/chi_ctrl.sv]
// Controller of the coalesced hash insert block: a one-hot state machine that
// sequences hashing, modulo, chain walk, free scan and store. Depends on chi_pkg.
module chi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  chi_pkg::sts_t sts_i,
  output chi_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    SClear   = 11'b000_0000_0001,
    SIdle    = 11'b000_0000_0010,
    SHash    = 11'b000_0000_0100,
    SDiv     = 11'b000_0000_1000,
    SHome    = 11'b000_0001_0000,
    SRead    = 11'b000_0010_0000,
    SCheck   = 11'b000_0100_0000,
    SScan    = 11'b000_1000_0000,
    SScanChk = 11'b001_0000_0000,
    SStore   = 11'b010_0000_0000,
    SResp    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    in_stall_o = 1'b1;
    cmd_o = '0;
    cmd_o.addr_sel = chi_pkg::AddrPos;
    cmd_o.pend_status = chi_pkg::StInserted;
    cmd_o.slot_sel = chi_pkg::SlotPos;
    case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SHash;
        end
      end
      SHash: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_done) state_d = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = SHome;
      end
      SHome: begin
        cmd_o.pos_home = 1'b1;
        state_d = SRead;
      end
      SRead: begin
        state_d = SCheck;
      end
      SCheck: begin
        if (sts_i.first && !sts_i.used) begin
          cmd_o.store_wr = 1'b1;
          cmd_o.pend_load = 1'b1;
          state_d = SResp;
        end else if (sts_i.match) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_status = chi_pkg::StDuplicate;
          state_d = SResp;
        end else if (sts_i.chain_end) begin
          state_d = SScan;
        end else begin
          cmd_o.pos_link = 1'b1;
          state_d = SRead;
        end
      end
      SScan: begin
        cmd_o.addr_sel = chi_pkg::AddrFree;
        if (sts_i.fp_full) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_status = chi_pkg::StFull;
          cmd_o.slot_sel = chi_pkg::SlotZero;
          state_d = SResp;
        end else begin
          state_d = SScanChk;
        end
      end
      SScanChk: begin
        cmd_o.addr_sel = chi_pkg::AddrFree;
        if (sts_i.used) begin
          cmd_o.scan_inc = 1'b1;
          state_d = SScan;
        end else begin
          cmd_o.link_wr = 1'b1;
          state_d = SStore;
        end
      end
      SStore: begin
        cmd_o.addr_sel = chi_pkg::AddrFree;
        cmd_o.store_wr = 1'b1;
        cmd_o.pend_load = 1'b1;
        cmd_o.slot_sel = chi_pkg::SlotFree;
        cmd_o.scan_inc = 1'b1;
        state_d = SResp;
      end
      SResp: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

[rtl/core/coalesced_hash_insert_dedup.sv]
// Coalesced hash insert with duplicate detection. A 128-bit key (words a..h)
// is hashed with PJW at one byte a cycle, reduced modulo the table size by a
// bit-serial remainder unit, then the home slot is read. A key that lands in
// a free home slot is stored there; otherwise the chain is walked entry by
// entry and a matching key is reported as a duplicate. A key that must go to
// a new slot has the free pointer examine slots until a free one is found,
// then it is linked and stored; a full table is reported in place of the
// scan. After reset the block clears its used flags and accepts no
// transaction until that is done. The result sits in an output register, so
// the next key is taken while a result still waits.
// Depends on chi_pkg, chi_ctrl and chi_dp.
module coalesced_hash_insert_dedup #(
  parameter int unsigned CAPACITY = chi_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chi_pkg::TsW-1:0]     cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [chi_pkg::WordW-1:0]   word_a_i,
  input  logic [chi_pkg::WordW-1:0]   word_b_i,
  input  logic [chi_pkg::WordW-1:0]   word_c_i,
  input  logic [chi_pkg::WordW-1:0]   word_d_i,
  input  logic [chi_pkg::WordW-1:0]   word_e_i,
  input  logic [chi_pkg::WordW-1:0]   word_f_i,
  input  logic [chi_pkg::WordW-1:0]   word_g_i,
  input  logic [chi_pkg::WordW-1:0]   word_h_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [chi_pkg::StatusW-1:0] status_o,
  output logic [chi_pkg::SlotW-1:0]   slot_o
);

  chi_pkg::cmd_t cmd;
  chi_pkg::sts_t sts;
  logic [chi_pkg::KeyW-1:0] key;

  assign key = {word_a_i, word_b_i, word_c_i, word_d_i,
                word_e_i, word_f_i, word_g_i, word_h_i};

  chi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chi_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_i       (key),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_o      (slot_o)
  );

endmodule
